@@ hdl/rmto_pkg.sv @@
// Shared constants, status codes and bundle types for the row-major tensor offset core.
// Depends on nothing; every other file in hdl refers to it by scoped names.
package rmto_pkg;

    localparam int MAX_RANK   = 4;
    localparam int ADDR_BITS  = 32;
    localparam int DIM_BITS   = 16;
    localparam int NDIMS      = 4;
    localparam int RANK_LIMIT = (MAX_RANK < NDIMS) ? MAX_RANK : NDIMS;

    localparam int RANK_W = 3;
    localparam int STAT_W = 3;
    localparam int IDX_W  = $clog2(NDIMS);
    localparam int CNT_W  = $clog2(NDIMS + 1);
    localparam int CFG_W  = 16;
    localparam int PROD_W = ADDR_BITS + DIM_BITS;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_RANK     = 3'd1;
    localparam logic [STAT_W-1:0] ST_INDEX    = 3'd2;
    localparam logic [STAT_W-1:0] ST_ZERO     = 3'd3;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd4;

    // Configuration register indexes.
    localparam logic [RANK_W-1:0] REG_RANK = 3'd0;
    localparam logic [RANK_W-1:0] REG_DIM0 = 3'd1;
    localparam logic [RANK_W-1:0] REG_LAST = 3'(NDIMS);

    typedef enum logic [2:0] {
        SH_IDLE   = 3'b001,
        SH_CHECK  = 3'b010,
        SH_STRIDE = 3'b100
    } shape_state_t;

    // Derived shape as seen by the request datapath.
    typedef struct packed {
        logic                                 busy;
        logic                                 rank_ok;
        logic [RANK_W-1:0]                    rank;
        logic [STAT_W-1:0]                    err;
        logic [IDX_W-1:0]                     fail;
        logic [NDIMS-1:0][DIM_BITS-1:0]       dim;
        logic [NDIMS-1:0][ADDR_BITS-1:0]      stride;
    } shape_t;

    // One lane's registered finding.
    typedef struct packed {
        logic                 bad;
        logic [ADDR_BITS-1:0] term;
    } lane_t;

    // Request-level control carried alongside the lanes.
    typedef struct packed {
        logic [STAT_W-1:0] err;
        logic [IDX_W-1:0]  fail;
        logic              rank_bad;
    } ctl_t;

endpackage

@@ hdl/rmto_shape.sv @@
// Configuration registers and the sequencer that checks the shape and derives strides.
// Depends on rmto_pkg; uses one shared 32x16 multiplier, one dimension per cycle.
module rmto_shape
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [rmto_pkg::RANK_W-1:0]     cfg_index,
    input  logic [rmto_pkg::CFG_W-1:0]      cfg_data,
    output rmto_pkg::shape_t                shape
);

    rmto_pkg::shape_state_t                                  state_reg, state_next;
    logic [rmto_pkg::RANK_W-1:0]                             rank_reg, rank_next;
    logic [rmto_pkg::NDIMS-1:0][rmto_pkg::DIM_BITS-1:0]      dim_reg, dim_next;
    logic [rmto_pkg::NDIMS-1:0][rmto_pkg::ADDR_BITS-1:0]     stride_reg, stride_next;
    logic [rmto_pkg::STAT_W-1:0]                             err_reg, err_next;
    logic [rmto_pkg::IDX_W-1:0]                              fail_reg, fail_next;
    logic [rmto_pkg::CNT_W-1:0]                              step_reg, step_next;
    logic [rmto_pkg::ADDR_BITS-1:0]                          count_reg, count_next;

    logic                                                    rank_ok;
    logic [rmto_pkg::CNT_W-1:0]                              step_dec;
    logic [rmto_pkg::IDX_W-1:0]                              step_idx;
    logic [rmto_pkg::ADDR_BITS-1:0]                          mul_a;
    logic [rmto_pkg::DIM_BITS-1:0]                           mul_b;
    logic [rmto_pkg::PROD_W-1:0]                             prod;
    logic                                                    cfg_hit;

    assign rank_ok  = (rank_reg <= rmto_pkg::RANK_W'(rmto_pkg::RANK_LIMIT));
    assign step_dec = step_reg - 1'b1;
    assign step_idx = step_reg[rmto_pkg::IDX_W-1:0];
    assign mul_a    = (state_reg == rmto_pkg::SH_CHECK) ? count_reg : stride_reg[step_idx];
    assign mul_b    = dim_reg[step_idx];
    assign prod     = mul_a * mul_b;
    assign cfg_hit  = cfg_write && (cfg_index <= rmto_pkg::REG_LAST);

    always_comb
    begin
        state_next  = state_reg;
        rank_next   = rank_reg;
        dim_next    = dim_reg;
        stride_next = stride_reg;
        err_next    = err_reg;
        fail_next   = fail_reg;
        step_next   = step_reg;
        count_next  = count_reg;

        unique case (state_reg)
            rmto_pkg::SH_IDLE:
            begin
            end
            rmto_pkg::SH_CHECK:
            begin
                // Forward pass: zero sizes and element-count overflow, outermost first.
                if (!rank_ok)
                begin
                    state_next = rmto_pkg::SH_IDLE;
                end
                else if (step_reg == rank_reg)
                begin
                    if (rank_reg >= 3'd2)
                    begin
                        state_next = rmto_pkg::SH_STRIDE;
                        step_next  = rank_reg - 1'b1;
                    end
                    else
                    begin
                        state_next = rmto_pkg::SH_IDLE;
                    end
                end
                else if (mul_b == '0)
                begin
                    err_next   = rmto_pkg::ST_ZERO;
                    fail_next  = step_idx;
                    state_next = rmto_pkg::SH_IDLE;
                end
                else if (prod[rmto_pkg::PROD_W-1:rmto_pkg::ADDR_BITS] != '0)
                begin
                    err_next   = rmto_pkg::ST_OVERFLOW;
                    fail_next  = step_idx;
                    state_next = rmto_pkg::SH_IDLE;
                end
                else
                begin
                    count_next = prod[rmto_pkg::ADDR_BITS-1:0];
                    step_next  = step_reg + 1'b1;
                end
            end
            rmto_pkg::SH_STRIDE:
            begin
                // Backward pass: each stride is the next stride times the next size.
                stride_next[step_dec[rmto_pkg::IDX_W-1:0]] = prod[rmto_pkg::ADDR_BITS-1:0];
                step_next = step_dec;
                if (step_reg == 3'd1)
                begin
                    state_next = rmto_pkg::SH_IDLE;
                end
            end
            default:
            begin
                state_next = rmto_pkg::SH_IDLE;
            end
        endcase

        // A write to a register index up to REG_LAST restarts the derivation from scratch.
        if (cfg_hit)
        begin
            if (cfg_index == rmto_pkg::REG_RANK)
            begin
                rank_next = cfg_data[rmto_pkg::RANK_W-1:0];
            end
            else
            begin
                dim_next[rmto_pkg::IDX_W'(cfg_index - rmto_pkg::REG_DIM0)] =
                    cfg_data[rmto_pkg::DIM_BITS-1:0];
            end
            for (int d = 0; d < rmto_pkg::NDIMS; d++)
            begin
                stride_next[d] = rmto_pkg::ADDR_BITS'(1);
            end
            err_next   = rmto_pkg::ST_OK;
            fail_next  = '0;
            step_next  = '0;
            count_next = rmto_pkg::ADDR_BITS'(1);
            state_next = rmto_pkg::SH_CHECK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmto_pkg::SH_IDLE;
            rank_reg  <= rmto_pkg::RANK_W'(1);
            for (int d = 0; d < rmto_pkg::NDIMS; d++)
            begin
                dim_reg[d]    <= rmto_pkg::DIM_BITS'(1);
                stride_reg[d] <= rmto_pkg::ADDR_BITS'(1);
            end
            err_reg   <= rmto_pkg::ST_OK;
            fail_reg  <= '0;
            step_reg  <= '0;
            count_reg <= rmto_pkg::ADDR_BITS'(1);
        end
        else
        begin
            state_reg  <= state_next;
            rank_reg   <= rank_next;
            dim_reg    <= dim_next;
            stride_reg <= stride_next;
            err_reg    <= err_next;
            fail_reg   <= fail_next;
            step_reg   <= step_next;
            count_reg  <= count_next;
        end
    end

    assign shape.busy    = (state_reg != rmto_pkg::SH_IDLE);
    assign shape.rank_ok = rank_ok;
    assign shape.rank    = rank_reg;
    assign shape.err     = err_reg;
    assign shape.fail    = fail_reg;
    assign shape.dim     = dim_reg;
    assign shape.stride  = stride_reg;

endmodule

@@ hdl/rmto_lane.sv @@
// One index lane: range check and index-times-stride product, registered.
// Depends on rmto_pkg; one copy per tensor dimension.
module rmto_lane
(
    input  logic                             clk,
    input  logic                             load,
    input  logic                             active,
    input  logic [rmto_pkg::DIM_BITS-1:0]    idx,
    input  logic [rmto_pkg::DIM_BITS-1:0]    dim,
    input  logic [rmto_pkg::ADDR_BITS-1:0]   stride,
    output rmto_pkg::lane_t                  lane
);

    rmto_pkg::lane_t                  lane_reg, lane_next;
    logic [rmto_pkg::PROD_W-1:0]      prod;

    assign prod = idx * stride;

    always_comb
    begin
        lane_next.bad  = active && (idx >= dim);
        lane_next.term = active ? prod[rmto_pkg::ADDR_BITS-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane = lane_reg;

endmodule

@@ hdl/rmto_merge.sv @@
// Merge stage: sums the lane terms, picks the status by priority and holds the result beat.
// Depends on rmto_pkg; fed by the rmto_lane registers and the request control register.
module rmto_merge
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s1_valid,
    input  rmto_pkg::lane_t [rmto_pkg::NDIMS-1:0]  lanes,
    input  rmto_pkg::ctl_t                         ctl,
    output logic                                   s1_ready,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [rmto_pkg::ADDR_BITS-1:0]         flat_offset,
    output logic [rmto_pkg::STAT_W-1:0]            status,
    output logic [rmto_pkg::IDX_W-1:0]             failing_dimension
);

    logic                              valid_reg, valid_next;
    logic [rmto_pkg::ADDR_BITS-1:0]    offset_reg, offset_next;
    logic [rmto_pkg::STAT_W-1:0]       status_reg, status_next;
    logic [rmto_pkg::IDX_W-1:0]        fail_reg, fail_next;
    logic [rmto_pkg::ADDR_BITS-1:0]    sum;
    logic                              any_bad;
    logic [rmto_pkg::IDX_W-1:0]        first_bad;

    assign s1_ready = !valid_reg || !out_stall;

    always_comb
    begin
        sum       = '0;
        any_bad   = 1'b0;
        first_bad = '0;
        for (int d = 0; d < rmto_pkg::NDIMS; d++)
        begin
            sum = sum + lanes[d].term;
            if (lanes[d].bad && !any_bad)
            begin
                any_bad   = 1'b1;
                first_bad = rmto_pkg::IDX_W'(d);
            end
        end
    end

    always_comb
    begin
        offset_next = '0;
        fail_next   = '0;
        priority if (ctl.err != rmto_pkg::ST_OK)
        begin
            status_next = ctl.err;
            fail_next   = ctl.fail;
        end
        else if (ctl.rank_bad)
        begin
            status_next = rmto_pkg::ST_RANK;
        end
        else if (any_bad)
        begin
            status_next = rmto_pkg::ST_INDEX;
            fail_next   = first_bad;
        end
        else
        begin
            status_next = rmto_pkg::ST_OK;
            offset_next = sum;
        end
        valid_next = s1_ready ? s1_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid && s1_ready)
        begin
            offset_reg <= offset_next;
            status_reg <= status_next;
            fail_reg   <= fail_next;
        end
    end

    assign out_valid         = valid_reg;
    assign flat_offset       = offset_reg;
    assign status            = status_reg;
    assign failing_dimension = fail_reg;

endmodule

@@ hdl/row_major_tensor_offset_core.sv @@
// Top level of the row-major tensor offset core: shape unit, four index lanes and merge stage.
// Depends on rmto_pkg, rmto_shape, rmto_lane and rmto_merge.
//
//   channel | handshake             | payload
//   --------+-----------------------+-----------------------------------------------
//   cfg     | cfg_write             | cfg_index, cfg_data
//   in      | in_valid / in_stall   | index_0..index_3, index_count
//   out     | out_valid / out_stall | flat_offset, status, failing_dimension
//
// One beat per cycle when neither stall holds the flow; an accepted request's result is
// registered first in the lane register, then in the merge register.
// in_stall is high in the cycle of a register write and then while the shape sequencer
// runs (forward check, then backward stride pass through one shared multiplier); for rank
// zero or a rank above the limit the check ends before any size is checked, a bad size ends it early.
// Reset loads rank one with all sizes one, already derived; no request is in flight.
// A stall on out backs up through the merge and lane registers to in_stall in the same cycle.
module row_major_tensor_offset_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [rmto_pkg::RANK_W-1:0]       cfg_index,
    input  logic [rmto_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rmto_pkg::DIM_BITS-1:0]     index_0,
    input  logic [rmto_pkg::DIM_BITS-1:0]     index_1,
    input  logic [rmto_pkg::DIM_BITS-1:0]     index_2,
    input  logic [rmto_pkg::DIM_BITS-1:0]     index_3,
    input  logic [rmto_pkg::RANK_W-1:0]       index_count,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [rmto_pkg::ADDR_BITS-1:0]    flat_offset,
    output logic [rmto_pkg::STAT_W-1:0]       status,
    output logic [rmto_pkg::IDX_W-1:0]        failing_dimension
);

    rmto_pkg::shape_t                                   shape;
    rmto_pkg::lane_t [rmto_pkg::NDIMS-1:0]              lanes;
    rmto_pkg::ctl_t                                     ctl_reg, ctl_next;
    logic [rmto_pkg::NDIMS-1:0][rmto_pkg::DIM_BITS-1:0] idx;
    logic                                               s1_valid_reg, s1_valid_next;
    logic                                               s1_ready;
    logic                                               load;

    assign idx[0] = index_0;
    assign idx[1] = index_1;
    assign idx[2] = index_2;
    assign idx[3] = index_3;

    // Requests wait while the shape is derived, a register is written or the output backs up.
    assign in_stall = (s1_valid_reg && !s1_ready) || shape.busy || cfg_write;
    assign load     = in_valid && !in_stall;

    rmto_shape u_shape
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .shape     (shape)
    );

    for (genvar d = 0; d < rmto_pkg::NDIMS; d++)
    begin : g_lane
        rmto_lane u_lane
        (
            .clk    (clk),
            .load   (load),
            .active (shape.rank > rmto_pkg::RANK_W'(d)),
            .idx    (idx[d]),
            .dim    (shape.dim[d]),
            .stride (shape.stride[d]),
            .lane   (lanes[d])
        );
    end

    always_comb
    begin
        ctl_next.err      = shape.err;
        ctl_next.fail     = shape.fail;
        ctl_next.rank_bad = !shape.rank_ok || (index_count != shape.rank);
        if (load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_ready)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg <= ctl_next;
        end
    end

    rmto_merge u_merge
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .s1_valid          (s1_valid_reg),
        .lanes             (lanes),
        .ctl               (ctl_reg),
        .s1_ready          (s1_ready),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .flat_offset       (flat_offset),
        .status            (status),
        .failing_dimension (failing_dimension)
    );

endmodule

@@ hdl/rmto_checker.sv @@
// Port-level checks for the row-major tensor offset core, bound to its top level.
// Depends on rmto_pkg and row_major_tensor_offset_core.
module rmto_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_write,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [rmto_pkg::ADDR_BITS-1:0]   flat_offset,
    input logic [rmto_pkg::STAT_W-1:0]      status,
    input logic [rmto_pkg::IDX_W-1:0]       failing_dimension
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(flat_offset) && $stable(status)
            && $stable(failing_dimension))
        else $error("result beat changed while stalled");

    // A register write never coincides with an accepted request.
    a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |-> in_stall)
        else $error("request accepted during a register write");

    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != rmto_pkg::ST_OK) |-> flat_offset == '0)
        else $error("non-zero offset with an error status");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((status == rmto_pkg::ST_OK) || (status == rmto_pkg::ST_RANK))
            |-> failing_dimension == '0)
        else $error("failing dimension set without a dimension error");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= rmto_pkg::ST_OVERFLOW)
        else $error("undefined status code");

endmodule

bind row_major_tensor_offset_core rmto_checker u_rmto_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write         (cfg_write),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .flat_offset       (flat_offset),
    .status            (status),
    .failing_dimension (failing_dimension)
);
